// File: design/ows_pkg.sv
// ----------------------------------------------------------------------------
// ows_pkg: shared types, constants and the CRC function of the search ROM engine
// Holds the operation codes, the item and result records, and the CRC-8 step.
// ----------------------------------------------------------------------------
package ows_pkg;

  // One past the last ROM bit position (positions run 1..64)
  localparam logic [6:0] IdBitsEnd   = 7'd65;
  // Positions below this lie in the family byte
  localparam logic [6:0] FamilyLimit = 7'd9;
  localparam logic [7:0] CrcInit     = 8'h00;
  // Dallas CRC-8, x^8+x^5+x^4+1, reflected
  localparam logic [7:0] CrcPoly     = 8'h8C;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_PAIR    = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0] operation;
    logic       presence;
    logic       true_bit;
    logic       complement_bit;
  } item_t;

  typedef struct packed {
    logic        direction;
    logic        write_valid;
    logic        done_res;
    logic        found;
    logic [63:0] device_id;
    logic        last_device;
    logic [3:0]  family_discrepancy;
  } result_t;

  // One LSB-first step of the running CRC
  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic din);
    logic [7:0] shifted;
    shifted = {1'b0, crc[7:1]};
    return (crc[0] ^ din) ? (shifted ^ CrcPoly) : shifted;
  endfunction

endpackage

// File: design/ows_engine.sv
// ----------------------------------------------------------------------------
// ows_engine: search state and per-item decision logic
// Keeps the ROM image and discrepancy bookkeeping; one item per enabled cycle.
// ----------------------------------------------------------------------------
module ows_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  ows_pkg::item_t   item,
  output ows_pkg::result_t res
);

  logic [63:0] rom_image,         rom_image_next;
  logic [6:0]  prior_discrepancy, prior_discrepancy_next;
  logic [3:0]  family_mark,       family_mark_next;
  logic        final_device_flag, final_device_flag_next;
  logic [6:0]  bit_position,      bit_position_next;
  logic [6:0]  newest_zero,       newest_zero_next;
  logic [7:0]  running_crc,       running_crc_next;
  logic        searching,         searching_next;

  logic        dir;
  logic [5:0]  idx;
  logic [6:0]  pos_inc;
  logic        pass_end;
  logic        id_good;

  assign idx      = 6'(bit_position - 7'd1);
  assign pos_inc  = bit_position + 7'd1;
  assign pass_end = (pos_inc >= ows_pkg::IdBitsEnd) || (pos_inc == 7'd0);

  // Direction: clear bit wins; else prior path, 1 at prior discrepancy, 0 past
  always_comb begin
    if (item.true_bit != item.complement_bit) begin
      dir = item.true_bit;
    end else if (bit_position < prior_discrepancy) begin
      dir = rom_image[idx];
    end else begin
      dir = (bit_position == prior_discrepancy);
    end
  end

  always_comb begin
    rom_image_next         = rom_image;
    prior_discrepancy_next = prior_discrepancy;
    family_mark_next       = family_mark;
    final_device_flag_next = final_device_flag;
    bit_position_next      = bit_position;
    newest_zero_next       = newest_zero;
    running_crc_next       = running_crc;
    searching_next         = searching;
    res                    = '0;
    id_good                = 1'b0;

    unique case (ows_pkg::op_t'(item.operation))
      ows_pkg::OP_START: begin
        if (!item.presence) begin
          searching_next = 1'b0;
          res.done_res   = 1'b1;
        end else begin
          searching_next    = 1'b1;
          bit_position_next = 7'd1;
          newest_zero_next  = 7'd0;
          running_crc_next  = ows_pkg::CrcInit;
        end
      end
      ows_pkg::OP_PAIR: begin
        if (searching) begin
          if (item.true_bit && item.complement_bit) begin
            searching_next = 1'b0;
            res.done_res   = 1'b1;
          end else begin
            if ((item.true_bit == item.complement_bit) && !dir) begin
              newest_zero_next = bit_position;
              if (bit_position < ows_pkg::FamilyLimit) begin
                family_mark_next = bit_position[3:0];
              end
            end
            rom_image_next[idx] = dir;
            running_crc_next    = ows_pkg::crc_step(running_crc, dir);
            res.direction       = dir;
            res.write_valid     = 1'b1;
            bit_position_next   = pos_inc;
            if (pass_end) begin
              prior_discrepancy_next = newest_zero_next;
              if (newest_zero_next == 7'd0) begin
                final_device_flag_next = 1'b1;
              end
              id_good = (rom_image_next[7:0] != 8'h00) && (running_crc_next == 8'h00);
              res.found     = id_good;
              res.device_id = id_good ? rom_image_next : 64'd0;
              searching_next = 1'b0;
              res.done_res   = 1'b1;
            end
          end
        end
      end
      ows_pkg::OP_RESTART: begin
        prior_discrepancy_next = 7'd0;
        family_mark_next       = 4'd0;
        final_device_flag_next = 1'b0;
        searching_next         = 1'b0;
      end
      default: begin
      end
    endcase

    res.last_device        = final_device_flag_next;
    res.family_discrepancy = family_mark_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_image         <= '0;
      prior_discrepancy <= '0;
      family_mark       <= '0;
      final_device_flag <= 1'b0;
      bit_position      <= 7'd1;
      newest_zero       <= '0;
      running_crc       <= ows_pkg::CrcInit;
      searching         <= 1'b0;
    end else if (step) begin
      rom_image         <= rom_image_next;
      prior_discrepancy <= prior_discrepancy_next;
      family_mark       <= family_mark_next;
      final_device_flag <= final_device_flag_next;
      bit_position      <= bit_position_next;
      newest_zero       <= newest_zero_next;
      running_crc       <= running_crc_next;
      searching         <= searching_next;
    end
  end

  // A found ID always closes the pass
  a_found_done: assert property (@(posedge clk) disable iff (rst)
    step && res.found |-> res.done_res)
    else $error("found without done");

  // Walk position stays within 1..65
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (bit_position != 7'd0) && (bit_position <= ows_pkg::IdBitsEnd))
    else $error("bit position out of range");

  // A restart clears the last-device flag and stops the walk
  a_restart_clear: assert property (@(posedge clk) disable iff (rst)
    step && (item.operation == ows_pkg::OP_RESTART) |=> !final_device_flag && !searching)
    else $error("restart left search state");

  // A write only comes from a bit pair taken while searching
  a_write_src: assert property (@(posedge clk) disable iff (rst)
    step && res.write_valid |-> searching && (item.operation == ows_pkg::OP_PAIR))
    else $error("write outside a search");

endmodule

// File: design/onewire_rom_search.sv
// ----------------------------------------------------------------------------
// onewire_rom_search: 1-Wire Search ROM decision engine
// Input register, combinational decision stage and result register.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one transaction per bus
//   event: a start after a reset pulse with its presence result, one bit pair
//   (true_bit, complement_bit) per ROM position, or a restart of enumeration.
//   The output channel (out_valid/out_ready) returns exactly one result per
//   input transaction, in order: the direction bit to write when write_valid
//   is set, done_res at the end of a pass, found and device_id on success,
//   and the current last_device flag and family_discrepancy.
//   An accepted transaction waits in the input register, moves to the result
//   register when that register is free or drains, and out_valid rises then.
//   Throughput is one transaction per cycle while the receiver does not stall,
//   set by the combinational decision stage that reads and updates the state.
//   Reset clears the search state: empty ROM image, no discrepancy, idle.
//   When the receiver stalls, the result register holds its transaction and
//   the input register fills; after that in_ready drops until out_ready.
// ----------------------------------------------------------------------------
module onewire_rom_search (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic        presence,
  input  logic        true_bit,
  input  logic        complement_bit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        direction,
  output logic        write_valid,
  output logic        done_res,
  output logic        found,
  output logic [63:0] device_id,
  output logic        last_device,
  output logic [3:0]  family_discrepancy
);

  // Input register stage
  logic             s1_valid;
  ows_pkg::item_t   s1_item;
  logic             s1_advance;

  // Result register stage
  ows_pkg::result_t step_res;
  ows_pkg::result_t out_res;

  // Advance the input stage whenever the result register is free or drains
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // Capture payload on acceptance; hold otherwise
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= '{operation:      operation,
                   presence:       presence,
                   true_bit:       true_bit,
                   complement_bit: complement_bit};
    end
  end

  // State update happens in the same cycle the item moves to the result register
  ows_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .step (s1_advance),
    .item (s1_item),
    .res  (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_res <= step_res;
    end
  end

  assign direction          = out_res.direction;
  assign write_valid        = out_res.write_valid;
  assign done_res           = out_res.done_res;
  assign found              = out_res.found;
  assign device_id          = out_res.device_id;
  assign last_device        = out_res.last_device;
  assign family_discrepancy = out_res.family_discrepancy;

  // A filled input stage moves on once the result register is free
  a_advance: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_valid |-> s1_advance)
    else $error("input stage stuck with free result register");

  // A stalled result is not overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !s1_advance)
    else $error("result register overwritten while stalled");

  // Each advance produces a valid result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s1_advance |=> out_valid)
    else $error("advance without result");

endmodule

// File: verif/onewire_rom_search_checker.sv
// ----------------------------------------------------------------------------
// onewire_rom_search_checker: result predictor and comparator
// Watches both channels of the search ROM engine. Every input transaction
// is run through a local model of the search state, and every result
// transaction is compared against the oldest prediction.
// ----------------------------------------------------------------------------
module onewire_rom_search_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  operation,
  input  logic        presence,
  input  logic        true_bit,
  input  logic        complement_bit,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        direction,
  input  logic        write_valid,
  input  logic        done_res,
  input  logic        found,
  input  logic [63:0] device_id,
  input  logic        last_device,
  input  logic [3:0]  family_discrepancy,
  output int          error_count,
  output int          pending_count,
  output int          result_count,
  output int          pass_count,
  output int          found_count
);

  // Local copy of the search state
  logic [63:0] rom_bits;
  logic [6:0]  last_disc;
  logic [3:0]  family_disc;
  logic        last_dev;
  logic [6:0]  bit_pos;
  logic [6:0]  zero_pos;
  logic [7:0]  crc_acc;
  logic        in_pass;

  ows_pkg::result_t predicted_results[$];

  task automatic search_step(input ows_pkg::item_t it, output ows_pkg::result_t res);
    logic [6:0] prev_pos;
    logic [5:0] idx;
    logic       dir;
    res = '0;
    case (it.operation)
      ows_pkg::OP_START: begin
        if (!it.presence) begin
          in_pass = 1'b0;
          res.done_res = 1'b1;
        end else begin
          in_pass  = 1'b1;
          bit_pos  = 7'd1;
          zero_pos = 7'd0;
          crc_acc  = ows_pkg::CrcInit;
        end
      end
      ows_pkg::OP_PAIR: begin
        if (in_pass) begin
          if (it.true_bit && it.complement_bit) begin
            in_pass = 1'b0;
            res.done_res = 1'b1;
          end else begin
            prev_pos = bit_pos - 7'd1;
            idx = prev_pos[5:0];
            if (it.true_bit != it.complement_bit) begin
              dir = it.true_bit;
            end else begin
              if (bit_pos < last_disc) dir = rom_bits[idx];
              else dir = (bit_pos == last_disc);
              if (!dir) begin
                zero_pos = bit_pos;
                if (bit_pos < ows_pkg::FamilyLimit) family_disc = bit_pos[3:0];
              end
            end
            rom_bits[idx] = dir;
            crc_acc = {1'b0, crc_acc[7:1]} ^
                      ((crc_acc[0] ^ dir) ? ows_pkg::CrcPoly : 8'h00);
            res.direction   = dir;
            res.write_valid = 1'b1;
            bit_pos = bit_pos + 7'd1;
            if (bit_pos >= ows_pkg::IdBitsEnd || bit_pos == 7'd0) begin
              last_disc = zero_pos;
              if (last_disc == 7'd0) last_dev = 1'b1;
              res.found = (rom_bits[7:0] != 8'h00) && (crc_acc == 8'h00);
              if (res.found) res.device_id = rom_bits;
              in_pass = 1'b0;
              res.done_res = 1'b1;
            end
          end
        end
      end
      ows_pkg::OP_RESTART: begin
        last_disc   = 7'd0;
        family_disc = 4'd0;
        last_dev    = 1'b0;
        in_pass     = 1'b0;
      end
      default: begin
      end
    endcase
    res.last_device        = last_dev;
    res.family_discrepancy = family_disc;
  endtask

  always @(posedge clk) begin : watch
    ows_pkg::result_t want;
    ows_pkg::result_t got;
    if (rst) begin
      rom_bits    = '0;
      last_disc   = '0;
      family_disc = '0;
      last_dev    = 1'b0;
      bit_pos     = 7'd1;
      zero_pos    = '0;
      crc_acc     = ows_pkg::CrcInit;
      in_pass     = 1'b0;
      predicted_results.delete();
      error_count   <= 0;
      pending_count <= 0;
      result_count  <= 0;
      pass_count    <= 0;
      found_count   <= 0;
    end else begin
      if (in_valid && in_ready) begin
        search_step({operation, presence, true_bit, complement_bit}, want);
        predicted_results.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = {direction, write_valid, done_res, found, device_id,
               last_device, family_discrepancy};
        result_count <= result_count + 1;
        if (got.done_res) pass_count <= pass_count + 1;
        if (got.found) found_count <= found_count + 1;
        if (predicted_results.size() == 0) begin
          if (error_count < 10)
            $display("result %0d arrived with nothing predicted", result_count);
          error_count <= error_count + 1;
        end else begin
          want = predicted_results.pop_front();
          if (got.direction !== want.direction || got.write_valid !== want.write_valid ||
              got.done_res !== want.done_res || got.found !== want.found ||
              got.device_id !== want.device_id || got.last_device !== want.last_device ||
              got.family_discrepancy !== want.family_discrepancy) begin
            if (error_count < 10) begin
              $display({"result %0d mismatch: expected dir=%b wv=%b done=%b",
                        " found=%b id=%h last=%b fam=%0d"},
                       result_count, want.direction, want.write_valid, want.done_res,
                       want.found, want.device_id, want.last_device,
                       want.family_discrepancy);
              $display("  actual dir=%b wv=%b done=%b found=%b id=%h last=%b fam=%0d",
                       got.direction, got.write_valid, got.done_res, got.found,
                       got.device_id, got.last_device, got.family_discrepancy);
            end
            error_count <= error_count + 1;
          end
        end
      end
      pending_count <= predicted_results.size();
    end
  end

endmodule

// File: verif/tb_onewire_rom_search.sv
// ----------------------------------------------------------------------------
// tb_onewire_rom_search: testbench of the search ROM decision engine
// Emulates a 1-Wire bus of a few devices and walks the full Search ROM
// enumeration against the engine, using its direction bits as a real master
// would, mixed with streamed passes and random noise. A checker beside the
// engine predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_onewire_rom_search;

  localparam int ItemTarget    = 900;
  localparam int QuietFrom     = 780;
  localparam int WatchdogLimit = 1000;
  localparam int MaxBus        = 4;
  // Operation code outside the defined set; the engine must ignore it
  localparam logic [1:0] OpUnused = 2'd3;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  operation;
  logic        presence;
  logic        true_bit;
  logic        complement_bit;
  logic        out_valid;
  logic        out_ready;
  logic        direction;
  logic        write_valid;
  logic        done_res;
  logic        found;
  logic [63:0] device_id;
  logic        last_device;
  logic [3:0]  family_discrepancy;

  int error_count;
  int pending_count;
  int result_count;
  int pass_count;
  int found_count;

  // Stimulus bookkeeping
  int   sent_cnt;
  int   recv_cnt;
  int   idle_cycles;
  int   gap_pct;
  int   enum_count;
  int   stream_count;
  int   noise_count;
  logic quiet;

  // Last result seen on the output channel, used as bus master feedback
  logic seen_dir;
  logic seen_done;
  logic seen_last;

  // Emulated bus population
  logic [63:0] bus_ids [MaxBus];
  int          bus_size;

  onewire_rom_search DUT (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .operation          (operation),
    .presence           (presence),
    .true_bit           (true_bit),
    .complement_bit     (complement_bit),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .direction          (direction),
    .write_valid        (write_valid),
    .done_res           (done_res),
    .found              (found),
    .device_id          (device_id),
    .last_device        (last_device),
    .family_discrepancy (family_discrepancy)
  );

  onewire_rom_search_checker u_check (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .operation          (operation),
    .presence           (presence),
    .true_bit           (true_bit),
    .complement_bit     (complement_bit),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .direction          (direction),
    .write_valid        (write_valid),
    .done_res           (done_res),
    .found              (found),
    .device_id          (device_id),
    .last_device        (last_device),
    .family_discrepancy (family_discrepancy),
    .error_count        (error_count),
    .pending_count      (pending_count),
    .result_count       (result_count),
    .pass_count         (pass_count),
    .found_count        (found_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Track results as the bus master sees them: count them and keep the
  // fields that steer the next bit pair.
  always @(posedge clk) begin
    if (rst) begin
      recv_cnt  <= 0;
      seen_dir  <= 1'b0;
      seen_done <= 1'b0;
      seen_last <= 1'b0;
    end else if (out_valid && out_ready) begin
      recv_cnt  <= recv_cnt + 1;
      seen_dir  <= direction;
      seen_done <= done_res;
      seen_last <= last_device;
    end
  end

  // Watchdog: end the run once neither channel has moved for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog expired after %0d idle cycles", idle_cycles);
      $display("tb_onewire_rom_search NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: stall in random bursts, keep ready high through the tail.
  initial begin
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_ready <= 1'b1;
      // Mix short ready windows with long stretches free of stalls
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(50, 200)) @(posedge clk);
      else repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // Dallas CRC-8 over the 56 bits below the CRC byte, LSB first
  function automatic logic [7:0] dallas_crc(input logic [55:0] data);
    logic [7:0] acc;
    logic       mix;
    acc = ows_pkg::CrcInit;
    for (int i = 0; i < 56; i++) begin
      mix = acc[0] ^ data[i];
      acc = acc >> 1;
      if (mix) acc = acc ^ ows_pkg::CrcPoly;
    end
    return acc;
  endfunction

  // Build a ROM ID; a related one shares most bits with base so that the
  // search hits discrepancies deep in the ID or inside the family byte.
  function automatic logic [63:0] make_device(input logic [63:0] base, input logic related);
    logic [55:0] body;
    logic [7:0]  crc;
    if (related) begin
      body = base[55:0];
      if ($urandom_range(0, 1) == 0) body[$urandom_range(0, 7)] ^= 1'b1;
      else body[$urandom_range(8, 55)] ^= 1'b1;
      if ($urandom_range(0, 1) == 0) body[$urandom_range(0, 55)] ^= 1'b1;
    end else begin
      body = 56'({$urandom(), $urandom()});
    end
    // Now and then an all-zero family byte or a broken CRC: never found
    if ($urandom_range(0, 7) == 0) body[7:0] = 8'h00;
    crc = dallas_crc(body);
    if ($urandom_range(0, 7) == 0) crc ^= 8'($urandom_range(1, 255));
    return {crc, body};
  endfunction

  // Present one input transaction and hold it until it is accepted.
  task automatic send(input logic [1:0] op, input logic pres, input logic tb_bit,
                      input logic cb_bit);
    if (!quiet && $urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    operation      <= op;
    presence       <= pres;
    true_bit       <= tb_bit;
    complement_bit <= cb_bit;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_cnt++;
    if (sent_cnt >= QuietFrom) quiet = 1'b1;
  endtask

  // Drop valid and wait until every sent transaction has its result.
  task automatic await_result();
    if (recv_cnt != sent_cnt) begin
      in_valid <= 1'b0;
      while (recv_cnt != sent_cnt) @(posedge clk);
    end
  endtask

  // One Search ROM pass on the emulated bus: wired-AND bit pairs from the
  // devices still in play, steered by the engine's direction bits.
  task automatic search_pass();
    logic [MaxBus-1:0] alive;
    logic              t;
    logic              c;
    send(ows_pkg::OP_START, bus_size > 0, 1'($urandom_range(0, 1)),
         1'($urandom_range(0, 1)));
    if (bus_size == 0) return;
    alive = '0;
    for (int k = 0; k < bus_size; k++) alive[k] = 1'b1;
    for (int i = 0; i < 64; i++) begin
      t = 1'b1;
      c = 1'b1;
      for (int k = 0; k < bus_size; k++) begin
        if (alive[k]) begin
          if (bus_ids[k][i]) c = 1'b0;
          else t = 1'b0;
        end
      end
      // Rare line glitch: corrupt the pair read from the bus
      if ($urandom_range(0, 399) == 0) {t, c} = 2'($urandom_range(0, 3));
      send(ows_pkg::OP_PAIR, 1'($urandom_range(0, 1)), t, c);
      await_result();
      if (seen_done) break;
      for (int k = 0; k < bus_size; k++)
        if (alive[k] && bus_ids[k][i] != seen_dir) alive[k] = 1'b0;
    end
  endtask

  // Enumerate a freshly populated bus until last_device, an empty bus or a limit is hit.
  task automatic enumerate_bus();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) bus_size = 0;
    else if (pick <= 4) bus_size = 1;
    else if (pick <= 7) bus_size = 2;
    else if (pick == 8) bus_size = 3;
    else bus_size = 4;
    bus_ids[0] = make_device('0, 1'b0);
    for (int k = 1; k < MaxBus; k++)
      bus_ids[k] = make_device(bus_ids[$urandom_range(0, k - 1)], $urandom_range(0, 3) != 0);
    send(ows_pkg::OP_RESTART, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
         1'($urandom_range(0, 1)));
    for (int p = 0; p <= bus_size + 1; p++) begin
      search_pass();
      await_result();
      if (seen_last || bus_size == 0 || sent_cnt >= ItemTarget) break;
    end
    enum_count++;
  endtask

  // A single-device pass streamed back to back, with some forced
  // discrepancies and the odd 1/1 pair; sometimes overrun into idle pairs.
  task automatic stream_pass();
    logic [63:0] id;
    int          r;
    int          n_pairs;
    id = make_device('0, 1'b0);
    n_pairs = ($urandom_range(0, 5) == 0) ? $urandom_range(65, 70) : 64;
    send(ows_pkg::OP_START, 1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    for (int i = 0; i < n_pairs; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) send(ows_pkg::OP_PAIR, 1'($urandom_range(0, 1)), 1'b0, 1'b0);
      else if (r == 99) send(ows_pkg::OP_PAIR, 1'($urandom_range(0, 1)), 1'b1, 1'b1);
      else send(ows_pkg::OP_PAIR, 1'($urandom_range(0, 1)), id[i % 64], ~id[i % 64]);
    end
    stream_count++;
  endtask

  // Short run of arbitrary transactions, unused operation code included.
  task automatic noise_burst();
    int n;
    n = $urandom_range(4, 24);
    for (int i = 0; i < n; i++)
      send(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
           1'($urandom_range(0, 1)));
    noise_count++;
  endtask

  initial begin
    int pick;
    sent_cnt       = 0;
    enum_count     = 0;
    stream_count   = 0;
    noise_count    = 0;
    quiet          = 1'b0;
    gap_pct        = 20;
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    operation      <= ows_pkg::OP_START;
    presence       <= 1'b0;
    true_bit       <= 1'b0;
    complement_bit <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: idle pairs, the unused code, no presence, start while
    // searching, a 1/1 failure, and restarts inside and outside a pass.
    send(ows_pkg::OP_PAIR, 1'b0, 1'b0, 1'b0);
    send(ows_pkg::OP_PAIR, 1'b1, 1'b1, 1'b1);
    send(OpUnused, 1'b1, 1'b1, 1'b1);
    send(OpUnused, 1'b0, 1'b0, 1'b0);
    send(ows_pkg::OP_START, 1'b0, 1'b1, 1'b1);
    send(ows_pkg::OP_START, 1'b1, 1'b0, 1'b0);
    send(ows_pkg::OP_PAIR, 1'b0, 1'b1, 1'b0);
    send(ows_pkg::OP_PAIR, 1'b1, 1'b0, 1'b1);
    send(ows_pkg::OP_PAIR, 1'b0, 1'b0, 1'b0);
    send(ows_pkg::OP_PAIR, 1'b1, 1'b0, 1'b0);
    send(ows_pkg::OP_START, 1'b1, 1'b1, 1'b1);
    send(ows_pkg::OP_PAIR, 1'b0, 1'b0, 1'b0);
    send(ows_pkg::OP_PAIR, 1'b0, 1'b1, 1'b1);
    send(ows_pkg::OP_PAIR, 1'b1, 1'b0, 1'b1);
    send(ows_pkg::OP_RESTART, 1'b1, 1'b1, 1'b1);
    send(ows_pkg::OP_START, 1'b1, 1'b0, 1'b1);
    send(ows_pkg::OP_PAIR, 1'b0, 1'b0, 1'b0);
    send(ows_pkg::OP_RESTART, 1'b0, 1'b0, 1'b0);
    send(ows_pkg::OP_PAIR, 1'b0, 1'b1, 1'b0);

    // Random: a mix of real enumerations, streamed passes and noise, enumerations the most common
    while (sent_cnt < ItemTarget) begin
      pick = $urandom_range(0, 2);
      gap_pct = (pick == 0) ? 0 : ((pick == 1) ? 15 : 40);
      pick = $urandom_range(0, 99);
      if (pick < 45) enumerate_bus();
      else if (pick < 70) stream_pass();
      else noise_burst();
    end

    // Drain: hold valid low until every result is back, then settle
    in_valid <= 1'b0;
    while (recv_cnt != sent_cnt || pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d transactions: %0d bus enumerations, %0d streamed passes, %0d noise bursts",
             sent_cnt, enum_count, stream_count, noise_count);
    $display("%0d results, %0d passes ended, %0d ROM IDs found, %0d mismatches",
             result_count, pass_count, found_count, error_count);
    if (error_count == 0 && pending_count == 0) begin
      $display("tb_onewire_rom_search OK");
    end else begin
      $display("tb_onewire_rom_search NOT OK");
    end
    $finish;
  end

endmodule
